[rtl/core/mono_framebuffer_draw_engine_top_macros.svh]
// ----------------------------------------------------------------------------
// mono frame buffer draw engine - assertion macros
// shared property wrappers, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_TOP_MACROS_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define MFDE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MFDE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mfde_pkg.sv]
// ----------------------------------------------------------------------------
// mfde_pkg
// shared types and constants of the frame buffer draw engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfde_pkg;

  localparam int PANEL_WIDTH_DEF  = 128;
  localparam int PANEL_HEIGHT_DEF = 64;
  localparam int BUFFER_BYTES_DEF = 1024;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // width for address arithmetic and range checks
  localparam int WIDE_W = 24;

  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_LINE  = 2'd1,
    OP_RECT  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // classified command; p is the column or major axis, q the row or minor axis
  typedef struct packed {
    op_t        op;
    logic       on;
    logic       steep;
    logic       ystep_neg;
    logic [7:0] p0;
    logic [7:0] q0;
    logic [8:0] p1;
    logic [8:0] q1;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [9:0] idx;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIXEL,
    ST_LINE,
    ST_RECT,
    ST_READ,
    ST_DRAIN,
    ST_RESP
  } state_t;

endpackage

[rtl/core/mfde_queue.sv]
// ----------------------------------------------------------------------------
// mfde_queue
// short command queue decoupling the front from the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mono_framebuffer_draw_engine_top_macros.svh"

module mfde_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mfde_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output mfde_pkg::cmd_t head_cmd,
  output logic          empty
);

  localparam int CNT_W = mfde_pkg::QPTR_W + 1;

  mfde_pkg::cmd_t slot_r [mfde_pkg::QUEUE_DEPTH];

  logic [mfde_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]            count_r;

  assign full     = (count_r == CNT_W'(mfde_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  `MFDE_ASSERT_IMP(a_no_push_full, push, !full, "push into full queue")
  `MFDE_ASSERT_IMP(a_no_pop_empty, pop, !empty, "pop from empty queue")
  `MFDE_ASSERT_NXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1,
                   "queue count did not follow push")

endmodule

[rtl/core/mfde_front.sv]
// ----------------------------------------------------------------------------
// mfde_front
// accepts input items, classifies them and prepares line and rectangle setup
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfde_front #(
  parameter int PANEL_WIDTH  = mfde_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = mfde_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mfde_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [mfde_pkg::IN_TUSER_W-1:0] in_tuser,
  input  logic                            clearing,
  input  logic                            q_full,
  output logic                            q_push,
  output mfde_pkg::cmd_t                  q_cmd
);

  logic [7:0] x0, y0, x1, y1, w, h;
  logic       on;
  logic [9:0] idx;
  logic [7:0] adx, ady;
  logic       steep, swap;
  logic [7:0] sa0, sb0, sa1, sb1;
  logic [7:0] p0, q0, p1, q1;
  logic [9:0] xsum, ysum;
  logic [8:0] xsat, ysat, xe, ye;

  assign x0  = in_tdata[7:0];
  assign y0  = in_tdata[15:8];
  assign x1  = in_tdata[23:16];
  assign y1  = in_tdata[31:24];
  assign w   = in_tdata[39:32];
  assign h   = in_tdata[47:40];
  assign on  = in_tdata[48];
  assign idx = in_tdata[58:49];

  assign in_tready = !q_full && !clearing;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    // line: pick major axis, then order endpoints along it
    adx   = (x1 >= x0) ? x1 - x0 : x0 - x1;
    ady   = (y1 >= y0) ? y1 - y0 : y0 - y1;
    steep = (ady > adx);
    sa0   = steep ? y0 : x0;
    sb0   = steep ? x0 : y0;
    sa1   = steep ? y1 : x1;
    sb1   = steep ? x1 : y1;
    swap  = (sa0 > sa1);
    p0    = swap ? sa1 : sa0;
    q0    = swap ? sb1 : sb0;
    p1    = swap ? sa0 : sa1;
    q1    = swap ? sb0 : sb1;

    // rectangle: exclusive end, saturated then clipped to the panel
    xsum = {2'b00, x0} + {2'b00, w};
    ysum = {2'b00, y0} + {2'b00, h};
    xsat = (xsum > 10'd256) ? 9'd256 : xsum[8:0];
    ysat = (ysum > 10'd256) ? 9'd256 : ysum[8:0];
    xe   = (xsat > 9'(PANEL_WIDTH))  ? 9'(PANEL_WIDTH)  : xsat;
    ye   = (ysat > 9'(PANEL_HEIGHT)) ? 9'(PANEL_HEIGHT) : ysat;

    q_cmd           = '0;
    q_cmd.op        = mfde_pkg::op_t'(in_tuser);
    q_cmd.on        = on;
    q_cmd.idx       = idx;
    unique case (mfde_pkg::op_t'(in_tuser))
      mfde_pkg::OP_LINE: begin
        q_cmd.steep     = steep;
        q_cmd.p0        = p0;
        q_cmd.q0        = q0;
        q_cmd.p1        = {1'b0, p1};
        q_cmd.q1        = {1'b0, q1};
        q_cmd.dx        = p1 - p0;
        q_cmd.dy        = (q1 >= q0) ? q1 - q0 : q0 - q1;
        q_cmd.ystep_neg = !(q0 < q1);
      end
      mfde_pkg::OP_RECT: begin
        q_cmd.p0 = x0;
        q_cmd.q0 = y0;
        q_cmd.p1 = xe;
        q_cmd.q1 = ye;
      end
      mfde_pkg::OP_PIXEL: begin
        q_cmd.p0 = x0;
        q_cmd.q0 = y0;
      end
      mfde_pkg::OP_READ: begin
        q_cmd.p0 = '0;
      end
      default: begin
        q_cmd.p0 = '0;
      end
    endcase
  end

endmodule

[rtl/core/mfde_back.sv]
// ----------------------------------------------------------------------------
// mfde_back
// executes commands: pixel sequencer, read-modify-write pipe, frame memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mono_framebuffer_draw_engine_top_macros.svh"

module mfde_back #(
  parameter int PANEL_WIDTH  = mfde_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = mfde_pkg::PANEL_HEIGHT_DEF,
  parameter int BUFFER_BYTES = mfde_pkg::BUFFER_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  mfde_pkg::cmd_t                   q_cmd,
  output logic                             q_pop,
  output logic                             clearing,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mfde_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int WW     = mfde_pkg::WIDE_W;

  typedef struct packed {
    logic pop;
    logic emit;
    logic out_load;
    logic clearing;
  } ctl_t;

  mfde_pkg::state_t state_r, state_nxt;
  ctl_t             ctl;

  logic [7:0]        mem [BUFFER_BYTES];
  logic [7:0]        rdata_r;
  logic [ADDR_W-1:0] clr_r;

  mfde_pkg::cmd_t    cmd_r;
  logic [7:0]        a_r, b_r;
  logic signed [9:0] err_r;

  // pixel pipe: stage 1 address and read, stage 2 modify and write
  logic              pix1_valid_r, pix1_on_r;
  logic [7:0]        pix1_x_r, pix1_y_r;
  logic              pix2_valid_r, pix2_on_r;
  logic [ADDR_W-1:0] pix2_addr_r;
  logic [2:0]        pix2_bit_r;
  logic              wr_valid_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [7:0]        wr_data_r;
  logic              dirty_r;
  logic              out_valid_r;
  logic [mfde_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic [7:0]        emit_x, emit_y;
  logic              emit_on;
  logic [WW-1:0]     bit_w, byte_w, idx_w;
  logic              pix1_in;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_en;
  logic [7:0]        base, mod_data, wr_data, mask;
  logic              idx_ok, line_last, row_last, col_last, rect_empty, out_free;
  logic signed [9:0] err_sub;
  logic [8:0]        b_inc, a_inc;

  assign out_free   = !out_valid_r || out_tready;
  assign line_last  = (a_r == cmd_r.p1[7:0]);
  assign b_inc      = {1'b0, b_r} + 9'd1;
  assign a_inc      = {1'b0, a_r} + 9'd1;
  assign row_last   = (b_inc >= cmd_r.q1);
  assign col_last   = (a_inc >= cmd_r.p1);
  assign rect_empty = ({1'b0, q_cmd.p0} >= q_cmd.p1) || ({1'b0, q_cmd.q0} >= q_cmd.q1);
  assign err_sub    = err_r - $signed({2'b00, cmd_r.dy});

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mfde_pkg::ST_CLEAR: begin
        if (clr_r == ADDR_W'(BUFFER_BYTES - 1)) state_nxt = mfde_pkg::ST_IDLE;
      end
      mfde_pkg::ST_IDLE: begin
        if (!q_empty) begin
          unique case (q_cmd.op)
            mfde_pkg::OP_PIXEL: state_nxt = mfde_pkg::ST_PIXEL;
            mfde_pkg::OP_LINE:  state_nxt = mfde_pkg::ST_LINE;
            mfde_pkg::OP_RECT:  state_nxt = rect_empty ? mfde_pkg::ST_DRAIN
                                                       : mfde_pkg::ST_RECT;
            mfde_pkg::OP_READ:  state_nxt = mfde_pkg::ST_READ;
            default:            state_nxt = mfde_pkg::ST_IDLE;
          endcase
        end
      end
      mfde_pkg::ST_PIXEL: state_nxt = mfde_pkg::ST_DRAIN;
      mfde_pkg::ST_LINE: begin
        if (line_last) state_nxt = mfde_pkg::ST_DRAIN;
      end
      mfde_pkg::ST_RECT: begin
        if (row_last && col_last) state_nxt = mfde_pkg::ST_DRAIN;
      end
      mfde_pkg::ST_READ:  state_nxt = mfde_pkg::ST_RESP;
      mfde_pkg::ST_DRAIN: begin
        if (!pix1_valid_r && !pix2_valid_r) state_nxt = mfde_pkg::ST_RESP;
      end
      mfde_pkg::ST_RESP: begin
        if (out_free) state_nxt = mfde_pkg::ST_IDLE;
      end
      default: state_nxt = mfde_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctl     = '0;
    emit_x  = cmd_r.p0;
    emit_y  = cmd_r.q0;
    emit_on = cmd_r.on;
    unique case (state_r)
      mfde_pkg::ST_CLEAR: ctl.clearing = 1'b1;
      mfde_pkg::ST_IDLE:  ctl.pop      = !q_empty;
      mfde_pkg::ST_PIXEL: ctl.emit     = 1'b1;
      mfde_pkg::ST_LINE: begin
        ctl.emit = 1'b1;
        emit_x   = cmd_r.steep ? b_r : a_r;
        emit_y   = cmd_r.steep ? a_r : b_r;
        emit_on  = 1'b1;
      end
      mfde_pkg::ST_RECT: begin
        ctl.emit = 1'b1;
        emit_x   = a_r;
        emit_y   = b_r;
      end
      mfde_pkg::ST_RESP: ctl.out_load = out_free;
      default: ctl.emit = 1'b0;
    endcase
  end

  assign q_pop    = ctl.pop;
  assign clearing = ctl.clearing;

  // stage 1 address: bit = y + x * height
  always_comb begin
    bit_w   = WW'(pix1_y_r) + WW'(pix1_x_r) * WW'(PANEL_HEIGHT);
    byte_w  = bit_w >> 3;
    pix1_in = ({1'b0, pix1_x_r} < 9'(PANEL_WIDTH)) &&
              ({1'b0, pix1_y_r} < 9'(PANEL_HEIGHT)) &&
              (byte_w < WW'(BUFFER_BYTES));
    idx_w   = WW'(cmd_r.idx);
    idx_ok  = (idx_w < WW'(BUFFER_BYTES));
    rd_addr = pix1_valid_r ? byte_w[ADDR_W-1:0] : idx_w[ADDR_W-1:0];
  end

  // stage 2 modify, forwarding the write of the previous cycle
  always_comb begin
    mask     = 8'(1) << pix2_bit_r;
    base     = (wr_valid_r && (wr_addr_r == pix2_addr_r)) ? wr_data_r : rdata_r;
    mod_data = pix2_on_r ? (base | mask) : (base & ~mask);
    wr_en    = ctl.clearing || pix2_valid_r;
    wr_addr  = ctl.clearing ? clr_r : pix2_addr_r;
    wr_data  = ctl.clearing ? 8'h00 : mod_data;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mfde_pkg::ST_CLEAR;
      clr_r        <= '0;
      pix1_valid_r <= 1'b0;
      pix2_valid_r <= 1'b0;
      wr_valid_r   <= 1'b0;
      dirty_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pix1_valid_r <= ctl.emit;
      pix2_valid_r <= pix1_valid_r && pix1_in;
      wr_valid_r   <= pix2_valid_r;
      dirty_r      <= dirty_r || pix2_valid_r;
      if (ctl.clearing) begin
        clr_r <= clr_r + 1'b1;
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pix1_x_r    <= emit_x;
    pix1_y_r    <= emit_y;
    pix1_on_r   <= emit_on;
    pix2_addr_r <= byte_w[ADDR_W-1:0];
    pix2_bit_r  <= bit_w[2:0];
    pix2_on_r   <= pix1_on_r;
    wr_addr_r   <= pix2_addr_r;
    wr_data_r   <= mod_data;
    if (ctl.pop) begin
      cmd_r <= q_cmd;
      a_r   <= q_cmd.p0;
      b_r   <= q_cmd.q0;
      err_r <= $signed({3'b000, q_cmd.dx[7:1]});
    end else if (state_r == mfde_pkg::ST_LINE) begin
      a_r <= a_r + 1'b1;
      if (err_sub < 0) begin
        b_r   <= cmd_r.ystep_neg ? b_r - 1'b1 : b_r + 1'b1;
        err_r <= err_sub + $signed({2'b00, cmd_r.dx});
      end else begin
        err_r <= err_sub;
      end
    end else if (state_r == mfde_pkg::ST_RECT) begin
      if (row_last) begin
        b_r <= cmd_r.q0;
        a_r <= a_r + 1'b1;
      end else begin
        b_r <= b_r + 1'b1;
      end
    end
    if (ctl.out_load) begin
      out_data_r <= {7'b0, dirty_r,
                     ((cmd_r.op == mfde_pkg::OP_READ) && idx_ok) ? rdata_r : 8'h00};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `MFDE_ASSERT_IMP(a_no_write_in_clear, state_r == mfde_pkg::ST_CLEAR,
                   !pix1_valid_r && !pix2_valid_r, "pixel in flight during clear pass")
  `MFDE_ASSERT_IMP(a_result_after_drain, ctl.out_load,
                   !pix1_valid_r && !pix2_valid_r, "result loaded before pipe drained")
  `MFDE_ASSERT_NXT(a_dirty_sticky, dirty_r, dirty_r, "dirty flag dropped")

endmodule

[rtl/core/mono_framebuffer_draw_engine_top.sv]
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine_top
// 1 bpp column-major frame buffer with pixel, line, rectangle and byte read
// ----------------------------------------------------------------------------
// latency to out_tvalid spans the draw state, which feeds a pixel, line or rectangle into
//   the pixel pipe, and the drain of that pipe; a byte read or empty rectangle feeds none
// throughput: one item at a time in the back end, the next popped the cycle
//   after a result is loaded if one is queued; one pixel read-modify-write per cycle
// reset: synchronous active-low; afterwards a clearing pass zeroes every byte of
//   the memory, with in_tready held low until it ends
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mono_framebuffer_draw_engine_top #(
  parameter int PANEL_WIDTH  = mfde_pkg::PANEL_WIDTH_DEF,   // 8 to 256
  parameter int PANEL_HEIGHT = mfde_pkg::PANEL_HEIGHT_DEF,  // 8 to 256
  parameter int BUFFER_BYTES = mfde_pkg::BUFFER_BYTES_DEF   // 8 to 8192
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input item channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // x_start[7:0] y_start[15:8] x_end[23:16] y_end[31:24] rect_width[39:32]
  // rect_height[47:40] pixel_on[48] byte_index[58:49], rest zero
  input  logic [mfde_pkg::IN_TDATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  logic [mfde_pkg::IN_TUSER_W-1:0]  in_tuser,
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // read_byte[7:0] dirty[8], rest zero
  output logic [mfde_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // front to queue
  logic           q_push, q_full;
  mfde_pkg::cmd_t push_cmd;
  // queue to back
  logic           q_pop, q_empty;
  mfde_pkg::cmd_t head_cmd;
  // back holds off the front while the memory is being zeroed
  logic           clearing;

  // front: handshake, decode of the operation, line octant and rectangle clip
  mfde_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .clearing  (clearing),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // short queue so the front keeps taking items while the back is drawing
  mfde_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  // back: pixel sequencer, read-modify-write pipe, memory and result register
  mfde_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
